// ===== src/hsl2rgb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants of the hsl to rgb converter: field widths, default precision, latency
// no dependencies

package hsl2rgb_pkg;

  localparam int HUE_W = 16;
  localparam int SAT_W = 17;
  localparam int LIT_W = 17;
  localparam int CH_W  = 8;

  localparam int FRAC_BITS_DEF = 16;

  // register stages from an accepted transaction to its result
  localparam int PIPE_LAT = 7;

endpackage

// ===== src/hsl2rgb_prep.sv =====
`timescale 1ns / 1ps
// front stages: clamp, saturation times chroma term, per-channel hue ramp position, ramp factor magnitude and sign
// depends on hsl2rgb_pkg

module hsl2rgb_prep
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic [HUE_W-1:0]       in_hue,
  input  logic [SAT_W-1:0]       in_saturation,
  input  logic [LIT_W-1:0]       in_lightness,
  output logic [2*FRAC_BITS-1:0] prod_o,
  output logic [FRAC_BITS:0]     lit_o,
  output logic [2:0][FRAC_BITS:0] kmag_o,
  output logic [2:0]             neg_o
);

  localparam int F   = FRAC_BITS;
  localparam int SXW = SAT_W + F;
  localparam int LXW = LIT_W + F;
  localparam int HXW = HUE_W + F;

  localparam logic [SXW-1:0] ONE_S  = SXW'(1) << F;
  localparam logic [LXW-1:0] ONE_L  = LXW'(1) << F;
  localparam logic [F:0]     ONE_F  = (F+1)'(1) << F;
  localparam logic [F+2:0]   ONE_3  = (F+3)'(1) << F;
  localparam logic [F+2:0]   THREE3 = (F+3)'(3) << F;
  localparam logic [F+3:0]   ONE_4  = (F+4)'(1) << F;
  localparam logic [F+3:0]   THREE4 = (F+4)'(3) << F;
  localparam logic [F+3:0]   TWO4   = (F+4)'(2) << F;
  localparam logic [F+3:0]   SEVEN4 = (F+4)'(7) << F;

  // stage 1
  logic [SXW-1:0] sat_x;
  logic [LXW-1:0] lit_x;
  logic [HXW-1:0] hue_x;
  logic [F-1:0]   h_c;
  logic [F:0]     sat_nxt, lit_nxt, lit_inv;
  logic [F-1:0]   mid_nxt;
  logic [F+1:0]   t3g_nxt;
  logic [F:0]     sat_r, lit_r;
  logic [F-1:0]   mid_r;
  logic [F+1:0]   t3g_r;

  always_comb begin
    sat_x   = {{F{1'b0}}, in_saturation};
    lit_x   = {{F{1'b0}}, in_lightness};
    hue_x   = {{F{1'b0}}, in_hue};
    h_c     = hue_x[F-1:0];
    sat_nxt = (sat_x > ONE_S) ? ONE_F : sat_x[F:0];
    lit_nxt = (lit_x > ONE_L) ? ONE_F : lit_x[F:0];
    lit_inv = ONE_F - lit_nxt;
    mid_nxt = (lit_nxt[F] || lit_nxt[F-1]) ? lit_inv[F-1:0] : lit_nxt[F-1:0];
    t3g_nxt = {2'b00, h_c} + {1'b0, h_c, 1'b0};
  end

  always_ff @(posedge clk) begin
    sat_r <= sat_nxt;
    lit_r <= lit_nxt;
    mid_r <= mid_nxt;
    t3g_r <= t3g_nxt;
  end

  // stage 2
  logic [2*F:0]         prod_full;
  logic [F+2:0]         tr_sum, tb_sum, tr_mod, tb_mod;
  logic [2:0][F+1:0]    t3_nxt;
  logic [2*F-1:0]       prod2_r;
  logic [F:0]           lit2_r;
  logic [2:0][F+1:0]    t3_r;

  always_comb begin
    prod_full = sat_r * mid_r;
    tr_sum    = {1'b0, t3g_r} + ONE_3;
    tb_sum    = {1'b0, t3g_r} + (ONE_3 << 1);
    tr_mod    = (tr_sum >= THREE3) ? tr_sum - THREE3 : tr_sum;
    tb_mod    = (tb_sum >= THREE3) ? tb_sum - THREE3 : tb_sum;
    t3_nxt[0] = tr_mod[F+1:0];
    t3_nxt[1] = t3g_r;
    t3_nxt[2] = tb_mod[F+1:0];
  end

  always_ff @(posedge clk) begin
    prod2_r <= prod_full[2*F-1:0];
    lit2_r  <= lit_r;
    t3_r    <= t3_nxt;
  end

  // stage 3: piecewise ramp factor, magnitude and sign
  logic [2:0][F:0] kmag_nxt;
  logic [2:0]      neg_nxt;
  logic [2*F-1:0]  prod3_r;
  logic [F:0]      lit3_r;
  logic [2:0][F:0] kmag_r;
  logic [2:0]      neg_r;

  always_comb begin
    logic [F+3:0] tx, ax, km;
    for (int i = 0; i < 3; i++) begin
      tx = {2'b00, t3_r[i]};
      ax = tx << 2;
      if ((tx << 1) < ONE_4) begin
        neg_nxt[i] = (ax < ONE_4);
        km         = neg_nxt[i] ? ONE_4 - ax : ax - ONE_4;
      end else if ((tx << 1) < THREE4) begin
        neg_nxt[i] = 1'b0;
        km         = ONE_4;
      end else if (tx < TWO4) begin
        neg_nxt[i] = (ax > SEVEN4);
        km         = neg_nxt[i] ? ax - SEVEN4 : SEVEN4 - ax;
      end else begin
        neg_nxt[i] = 1'b1;
        km         = ONE_4;
      end
      kmag_nxt[i] = km[F:0];
    end
  end

  always_ff @(posedge clk) begin
    prod3_r <= prod2_r;
    lit3_r  <= lit2_r;
    kmag_r  <= kmag_nxt;
    neg_r   <= neg_nxt;
  end

  assign prod_o = prod3_r;
  assign lit_o  = lit3_r;
  assign kmag_o = kmag_r;
  assign neg_o  = neg_r;

endmodule

// ===== src/hsl2rgb_chan.sv =====
`timescale 1ns / 1ps
// back stages of one color channel: exact scaled sum, round half up to 8 bits
// depends on hsl2rgb_pkg

module hsl2rgb_chan
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic [2*FRAC_BITS-1:0] prod_i,
  input  logic [FRAC_BITS:0]     lit_i,
  input  logic [FRAC_BITS:0]     kmag_i,
  input  logic                   neg_i,
  output logic [CH_W-1:0]        ch_o
);

  localparam int F   = FRAC_BITS;
  localparam int BW  = F + 10;
  localparam int PW  = 2 * F + 1;
  localparam int PKW = 3 * F + 1;
  localparam int NW  = 3 * F + 10;

  localparam logic [BW-1:0] ONE_B = BW'(1) << F;

  // stage 4: split partial products, lightness base
  logic [PW-1:0] plo_nxt, phi_nxt;
  logic [BW-1:0] lx, base_nxt;
  logic [PW-1:0] plo_r, phi_r;
  logic [BW-1:0] base4_r;
  logic          neg4_r;

  always_comb begin
    plo_nxt  = prod_i[F-1:0] * kmag_i;
    phi_nxt  = prod_i[2*F-1:F] * kmag_i;
    lx       = BW'(lit_i);
    base_nxt = (lx << 9) - (lx << 1) + ONE_B;
  end

  always_ff @(posedge clk) begin
    plo_r   <= plo_nxt;
    phi_r   <= phi_nxt;
    base4_r <= base_nxt;
    neg4_r  <= neg_i;
  end

  // stage 5: recombine partial products
  logic [PKW-1:0] pk_nxt;
  logic [PKW-1:0] pk_r;
  logic [BW-1:0]  base5_r;
  logic           neg5_r;

  always_comb begin
    pk_nxt = {phi_r[PKW-F-1:0], {F{1'b0}}} + PKW'(plo_r);
  end

  always_ff @(posedge clk) begin
    pk_r    <= pk_nxt;
    base5_r <= base4_r;
    neg5_r  <= neg4_r;
  end

  // stage 6: scale by 510
  logic [NW-1:0] pkx, term_nxt;
  logic [NW-1:0] term_r;
  logic [BW-1:0] base6_r;
  logic          neg6_r;

  always_comb begin
    pkx      = NW'(pk_r);
    term_nxt = (pkx << 9) - (pkx << 1);
  end

  always_ff @(posedge clk) begin
    term_r  <= term_nxt;
    base6_r <= base5_r;
    neg6_r  <= neg5_r;
  end

  // stage 7: signed combine, keep bits above the rounding point
  logic [NW-1:0]   bx, num;
  logic [CH_W-1:0] ch_nxt;
  logic [CH_W-1:0] ch_r;

  always_comb begin
    bx     = {base6_r, {(2*F){1'b0}}};
    num    = neg6_r ? bx - term_r : bx + term_r;
    ch_nxt = num[3*F+8:3*F+1];
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
  end

  assign ch_o = ch_r;

endmodule

// ===== src/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// top level of the hsl to rgb converter: front stages, three channel pipelines, valid line
// depends on hsl2rgb_pkg, hsl2rgb_prep, hsl2rgb_chan

// usage
//   input: drive in_hue, in_saturation, in_lightness and raise start; the transaction
//   is taken at a rising edge with start high and busy low. busy is low whenever
//   rst_n is high, so one color can enter every cycle.
//   output: out_valid is high for one cycle with out_red, out_green, out_blue;
//   the result is taken at the edge that ends that cycle.
//   throughput: one color per cycle, set by a 7-stage pipeline with no feedback
//   saturation and lightness above 1.0 are clamped, hue wraps modulo one turn
//   reset: synchronous, clears the valid line; busy is high while rst_n is low,
//   so no transaction is taken during reset
//   the receiver cannot stall: every result is presented exactly once

module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [HUE_W-1:0] in_hue,
  input  logic [SAT_W-1:0] in_saturation,
  input  logic [LIT_W-1:0] in_lightness,
  output logic             out_valid,
  output logic [CH_W-1:0]  out_red,
  output logic [CH_W-1:0]  out_green,
  output logic [CH_W-1:0]  out_blue
);

  localparam int F = FRAC_BITS;

  logic                 accept;
  logic [PIPE_LAT-1:0]  vld_r;
  logic [2*F-1:0]       prod;
  logic [F:0]           lit;
  logic [2:0][F:0]      kmag;
  logic [2:0]           neg;
  logic [2:0][CH_W-1:0] ch;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], accept};
    end
  end

  hsl2rgb_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk          (clk),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_lightness (in_lightness),
    .prod_o       (prod),
    .lit_o        (lit),
    .kmag_o       (kmag),
    .neg_o        (neg)
  );

  for (genvar i = 0; i < 3; i++) begin : g_chan
    hsl2rgb_chan #(
      .FRAC_BITS(FRAC_BITS)
    ) u_chan (
      .clk   (clk),
      .prod_i(prod),
      .lit_i (lit),
      .kmag_i(kmag[i]),
      .neg_i (neg[i]),
      .ch_o  (ch[i])
    );
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_red   = ch[0];
  assign out_green = ch[1];
  assign out_blue  = ch[2];

endmodule

// ===== src/hsl2rgb_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the hsl to rgb converter and the bind that attaches them
// depends on hsl2rgb_pkg and hsl_to_rgb_converter

module hsl2rgb_checker
  import hsl2rgb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [SAT_W-1:0] in_saturation,
  input logic [LIT_W-1:0] in_lightness,
  input logic             out_valid,
  input logic [CH_W-1:0]  out_red,
  input logic [CH_W-1:0]  out_green,
  input logic [CH_W-1:0]  out_blue
);

  // every accepted transaction yields a result on out_valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted transaction produced no result");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##PIPE_LAT !out_valid)
    else $error("result without a transaction");

  // zero saturation gives grey
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_saturation == '0) |->
      ##PIPE_LAT (out_red == out_green && out_green == out_blue))
    else $error("zero saturation did not give grey");

  // zero lightness gives black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_lightness == '0) |->
      ##PIPE_LAT (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("zero lightness did not give black");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (.*);

// ===== tb/sv/tb_hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// testbench for hsl_to_rgb_converter: directed and random colors checked against a bit-exact
// predictor of the hsl ramp and rounding; depends on hsl2rgb_pkg and the converter rtl

module tb_hsl_to_rgb_converter;
  import hsl2rgb_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [LIT_W-1:0] lit;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } color_txn_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [HUE_W-1:0] in_hue = '0;
  logic [SAT_W-1:0] in_saturation = '0;
  logic [LIT_W-1:0] in_lightness = '0;
  logic             out_valid;
  logic [CH_W-1:0]  out_red;
  logic [CH_W-1:0]  out_green;
  logic [CH_W-1:0]  out_blue;

  color_txn_t  pending_colors[$];
  int          errors = 0;
  int unsigned cycles = 0;
  int          send_idle_pct = 0;

  hsl_to_rgb_converter #(.FRAC_BITS(FB)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_lightness (in_lightness),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ramp value at 3*t, scaled by 255 and rounded half up
  function automatic logic [CH_W-1:0] ramp_channel(input longint unsigned l,
                                                   input longint unsigned s,
                                                   input longint unsigned m,
                                                   input longint unsigned t3);
    longint unsigned a;
    longint unsigned kmag;
    bit              neg;
    logic [127:0]    num;
    logic [127:0]    term;
    a = 0;
    if (2 * t3 < ONE) begin
      a = 4 * t3;
      neg = (a < ONE);
      kmag = neg ? ONE - a : a - ONE;
    end else if (2 * t3 < 3 * ONE) begin
      neg = 1'b0;
      kmag = ONE;
    end else if (t3 < 2 * ONE) begin
      a = 4 * t3;
      neg = (a > 7 * ONE);
      kmag = neg ? a - 7 * ONE : 7 * ONE - a;
    end else begin
      neg = 1'b1;
      kmag = ONE;
    end
    num = 128'(510 * l + ONE) * 128'(ONE * ONE);
    term = 128'(510 * s * m) * 128'(kmag);
    num = neg ? num - term : num + term;
    return num[3*FB+1 +: CH_W];
  endfunction

  function automatic color_txn_t predict_rgb(input logic [HUE_W-1:0] hue,
                                             input logic [SAT_W-1:0] sat,
                                             input logic [LIT_W-1:0] lit);
    color_txn_t      c;
    longint unsigned h, s, l, m, t3g, t3r, t3b;
    h = longint'(hue) & (ONE - 1);
    s = (sat > ONE) ? ONE : longint'(sat);
    l = (lit > ONE) ? ONE : longint'(lit);
    m = (2 * l < ONE) ? l : ONE - l;
    t3g = 3 * h;
    t3r = (t3g + ONE) % (3 * ONE);
    t3b = (t3g + 2 * ONE) % (3 * ONE);
    c.hue = hue;
    c.sat = sat;
    c.lit = lit;
    c.red = ramp_channel(l, s, m, t3r);
    c.green = ramp_channel(l, s, m, t3g);
    c.blue = ramp_channel(l, s, m, t3b);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want,
                                 input color_txn_t c);
    $display("mismatch %s: got %0d expected %0d (hue %0d sat %0d lit %0d)",
             what, got, want, c.hue, c.sat, c.lit);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    color_txn_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_colors.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (pending_colors.size() == 0) begin
          want = '0;
          report_mismatch("unexpected result", int'(out_red), 0, want);
        end else begin
          want = pending_colors.pop_front();
          if (out_red !== want.red)
            report_mismatch("red", int'(out_red), int'(want.red), want);
          if (out_green !== want.green)
            report_mismatch("green", int'(out_green), int'(want.green), want);
          if (out_blue !== want.blue)
            report_mismatch("blue", int'(out_blue), int'(want.blue), want);
        end
      end
      if (start && !busy) pending_colors.push_back(predict_rgb(in_hue, in_saturation,
                                                               in_lightness));
    end
  end

  task automatic send_color(input logic [HUE_W-1:0] h, input logic [SAT_W-1:0] s,
                            input logic [LIT_W-1:0] l);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_hue <= h;
    in_saturation <= s;
    in_lightness <= l;
    do @(posedge clk); while (busy);
  endtask

  task automatic test_directed();
    send_color(16'd0, 17'd0, 17'd0);
    send_color(16'd65535, 17'd65536, 17'd65536);
    send_color(16'd0, 17'd65536, 17'd32768);
    send_color(16'd21845, 17'd65536, 17'd32768);
    send_color(16'd43691, 17'd65536, 17'd32768);
    send_color(16'd43690, 17'd65536, 17'd32768);
    // zero saturation gives grey
    send_color(16'd12345, 17'd0, 17'd40000);
    send_color(16'd30000, 17'd0, 17'd65536);
    send_color(16'd65535, 17'd0, 17'd1);
    // saturation and lightness above one clamp
    send_color(16'd0, 17'd131071, 17'd131071);
    send_color(16'd50000, 17'd70000, 17'd20000);
    send_color(16'd10000, 17'd30000, 17'd100000);
    // hue on and next to segment edges
    send_color(16'd32768, 17'd65536, 17'd32768);
    send_color(16'd32767, 17'd65536, 17'd32768);
    send_color(16'd10922, 17'd65536, 17'd16384);
    send_color(16'd10923, 17'd65536, 17'd49152);
    send_color(16'd54613, 17'd40000, 17'd32767);
    send_color(16'd54614, 17'd40000, 17'd32769);
    send_color(16'd21846, 17'd65535, 17'd1);
    send_color(16'd43690, 17'd1, 17'd65535);
    send_color(16'd65535, 17'd65536, 17'd0);
    send_color(16'd1, 17'd65535, 17'd65535);
    send_color(16'd0, 17'd65536, 17'd32767);
  endtask

  task automatic test_random(input int count);
    logic [HUE_W-1:0] h;
    logic [SAT_W-1:0] s;
    logic [LIT_W-1:0] l;
    int               edges[12] = '{0, 65535, 32768, 32767, 21845, 21846,
                                    43690, 43691, 10922, 10923, 54613, 54614};
    repeat (count) begin
      h = HUE_W'($urandom());
      s = SAT_W'($urandom_range(0, 65536));
      l = LIT_W'($urandom_range(0, 65536));
      case ($urandom_range(9))
        6: s = SAT_W'($urandom_range(65537, 131071));
        7: s = '0;
        8: h = HUE_W'(edges[$urandom_range(11)] + int'($urandom_range(0, 2)) - 1);
        9: begin
          s = SAT_W'($urandom());
          l = LIT_W'($urandom());
        end
        default: ;
      endcase
      send_color(h, s, l);
    end
  endtask

  task automatic test_pause_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    send_color(16'd20000, 17'd50000, 17'd30000);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 26;
    test_directed();
    test_random(300);
    test_pause_until_drained();
    send_idle_pct = 53;
    test_random(300);
    send_idle_pct = 0;
    test_random(300);

    @(negedge clk);
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (pending_colors.size() != 0) begin
      $display("%0d expected results never arrived", pending_colors.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
